FILE: rtl/core/riff_wave_pcm_parser_unit_macros.svh
`ifndef RIFF_WAVE_PCM_PARSER_UNIT_MACROS_SVH
`define RIFF_WAVE_PCM_PARSER_UNIT_MACROS_SVH

// condition holds at every edge out of reset
`define RWP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define RWP_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RWP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/rwp_pkg.sv
`default_nettype none

package rwp_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 72;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_FORMAT = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NOT_WAVE    = 3'd0,
    ERR_FMT_SIZE    = 3'd1,
    ERR_NOT_PCM     = 3'd2,
    ERR_NO_FMT      = 3'd3,
    ERR_BAD_BITS    = 3'd4
  } err_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] sample;
    logic [31:0]        rate;
    logic [15:0]        bits;
    err_t               err;
  } event_t;

endpackage

`default_nettype wire

FILE: rtl/core/rwp_front.sv
`default_nettype none

`include "riff_wave_pcm_parser_unit_macros.svh"

module rwp_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [7:0]     in_data,
  input  wire logic           queue_full,
  output logic                push,
  output rwp_pkg::event_t     ev
);

  typedef enum logic [5:0] {
    PH_HEADER = 6'b000001,
    PH_FORM   = 6'b000010,
    PH_FMT    = 6'b000100,
    PH_DATA   = 6'b001000,
    PH_SKIP   = 6'b010000,
    PH_HALT   = 6'b100000
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  pos, pos_next;
  logic [31:0] tag, tag_next;
  logic [31:0] left, left_next;
  logic [63:0] fmt, fmt_next;
  logic [15:0] bps, bps_next;
  logic        seen, seen_next;
  logic [7:0]  hold, hold_next;

  logic        fire;
  logic        fail;
  rwp_pkg::err_t fail_code;

  assign in_ready = !queue_full;
  assign fire     = in_valid && in_ready;

  always_comb begin
    phase_next = phase;
    pos_next   = pos;
    tag_next   = tag;
    left_next  = left;
    fmt_next   = fmt;
    bps_next   = bps;
    seen_next  = seen;
    hold_next  = hold;
    fail       = 1'b0;
    fail_code  = rwp_pkg::ERR_NOT_WAVE;
    push       = 1'b0;
    ev         = '0;
    if (fire) begin
      case (phase)
        PH_HEADER: begin
          pos_next = pos + 4'd1;
          if (pos < 4'd4) begin
            tag_next[{pos[1:0], 3'b000} +: 8] = in_data;
          end else begin
            left_next[{pos[1:0], 3'b000} +: 8] = in_data;
            if (pos == 4'd7) begin
              pos_next = '0;
              if (tag == rwp_pkg::TAG_RIFF) begin
                tag_next   = '0;
                phase_next = PH_FORM;
              end else if (tag == rwp_pkg::TAG_FMT) begin
                if (left_next != 32'd16) begin
                  fail      = 1'b1;
                  fail_code = rwp_pkg::ERR_FMT_SIZE;
                end else begin
                  phase_next = PH_FMT;
                end
              end else if (tag == rwp_pkg::TAG_DATA) begin
                if (!seen) begin
                  fail      = 1'b1;
                  fail_code = rwp_pkg::ERR_NO_FMT;
                end else if (bps != 16'd8 && bps != 16'd16) begin
                  fail      = 1'b1;
                  fail_code = rwp_pkg::ERR_BAD_BITS;
                end else begin
                  phase_next = (left_next == '0) ? PH_HEADER : PH_DATA;
                end
              end else begin
                phase_next = (left_next == '0) ? PH_HEADER : PH_SKIP;
              end
            end
          end
        end
        PH_FORM: begin
          tag_next[{pos[1:0], 3'b000} +: 8] = in_data;
          pos_next = pos + 4'd1;
          if (pos >= 4'd3) begin
            pos_next = '0;
            if (tag_next != rwp_pkg::TAG_WAVE) begin
              fail      = 1'b1;
              fail_code = rwp_pkg::ERR_NOT_WAVE;
            end else begin
              tag_next   = '0;
              phase_next = PH_HEADER;
            end
          end
        end
        PH_FMT: begin
          if (pos < 4'd8) begin
            fmt_next[{pos[2:0], 3'b000} +: 8] = in_data;
          end else if (pos == 4'd14) begin
            bps_next[7:0] = in_data;
          end else if (pos == 4'd15) begin
            bps_next[15:8] = in_data;
          end
          pos_next = pos + 4'd1;
          if (pos == 4'd15) begin
            pos_next = '0;
            if (fmt_next[15:0] != 16'd1 || fmt_next[31:16] != 16'd1) begin
              fail      = 1'b1;
              fail_code = rwp_pkg::ERR_NOT_PCM;
            end else begin
              seen_next  = 1'b1;
              phase_next = PH_HEADER;
              push       = 1'b1;
              ev.kind    = rwp_pkg::KIND_FORMAT;
              ev.rate    = fmt_next[63:32];
              ev.bits    = bps_next;
            end
          end
        end
        PH_DATA: begin
          left_next = left - 32'd1;
          if (bps == 16'd8) begin
            push      = 1'b1;
            ev.kind   = rwp_pkg::KIND_SAMPLE;
            ev.sample = {8'd0, in_data};
            ev.rate   = fmt[63:32];
            ev.bits   = bps;
          end else if (!pos[0]) begin
            // a lone last byte is dropped
            if (left != 32'd1) begin
              hold_next = in_data;
              pos_next  = 4'd1;
            end
          end else begin
            pos_next  = '0;
            push      = 1'b1;
            ev.kind   = rwp_pkg::KIND_SAMPLE;
            ev.sample = {in_data, hold};
            ev.rate   = fmt[63:32];
            ev.bits   = bps;
          end
          if (left_next == '0) begin
            pos_next   = '0;
            phase_next = PH_HEADER;
          end
        end
        PH_SKIP: begin
          left_next = left - 32'd1;
          if (left_next == '0) begin
            pos_next   = '0;
            phase_next = PH_HEADER;
          end
        end
        default: begin
        end
      endcase
      if (fail) begin
        phase_next = PH_HALT;
        push       = 1'b1;
        ev         = '0;
        ev.kind    = rwp_pkg::KIND_ERROR;
        ev.err     = fail_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      pos   <= '0;
      tag   <= '0;
      left  <= '0;
      fmt   <= '0;
      bps   <= '0;
      seen  <= 1'b0;
      hold  <= '0;
    end else begin
      phase <= phase_next;
      pos   <= pos_next;
      tag   <= tag_next;
      left  <= left_next;
      fmt   <= fmt_next;
      bps   <= bps_next;
      seen  <= seen_next;
      hold  <= hold_next;
    end
  end

  `RWP_ASSERT_NEXT(a_halt_sticky, phase == PH_HALT, phase == PH_HALT, "halt state left")
  `RWP_ASSERT_IMPLY(a_halt_silent, phase == PH_HALT, !push, "word pushed while halted")
  `RWP_ASSERT_IMPLY(a_data_pos, phase == PH_DATA, pos <= 4'd1, "sample byte position bad")

endmodule

`default_nettype wire

FILE: rtl/core/rwp_queue.sv
`default_nettype none

`include "riff_wave_pcm_parser_unit_macros.svh"

module rwp_queue #(
  parameter int DEPTH = rwp_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire rwp_pkg::event_t  wr_data,
  output logic                  full,
  input  wire logic             pop,
  output rwp_pkg::event_t       rd_data,
  output logic                  empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  rwp_pkg::event_t mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  `RWP_ASSERT_ALWAYS(a_count_bound, count <= CW'(DEPTH), "queue count past depth")
  `RWP_ASSERT_IMPLY(a_no_overflow, push, !full, "push into full queue")
  `RWP_ASSERT_IMPLY(a_no_underflow, pop, !empty, "pop from empty queue")

endmodule

`default_nettype wire

FILE: rtl/core/rwp_back.sv
`default_nettype none

module rwp_back (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               empty,
  input  wire rwp_pkg::event_t                    rd_data,
  output logic                                    pop,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [rwp_pkg::OUT_TDATA_W-1:0]         out_data
);

  rwp_pkg::event_t hold;

  assign pop = !empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      hold <= rd_data;
    end
  end

  // kind, sample, rate, bits, error code from bit 0 up
  assign out_data = {3'd0, hold.err, hold.bits, hold.rate, hold.sample, hold.kind};

endmodule

`default_nettype wire

FILE: rtl/core/riff_wave_pcm_parser_unit.sv
// two register stages: a result word is written into the result queue at the edge that takes
// the byte causing it, then moves into the output register that drives m_axis
// throughput: one byte per cycle while the result queue has room; the parser state updates once per byte
// s_axis_tready drops only while the result queue is full under back-pressure
// reset: synchronous, clears the parser to awaiting a chunk header and empties the queue
`default_nettype none

module riff_wave_pcm_parser_unit #(
  parameter int QUEUE_DEPTH = rwp_pkg::QUEUE_DEPTH
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [rwp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // data_byte
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // event_kind, sample_value, rate_hz, sample_bits, error_code, zero pad
  output logic [rwp_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);

  logic            push;
  logic            full;
  logic            pop;
  logic            empty;
  rwp_pkg::event_t wr_data;
  rwp_pkg::event_t rd_data;

  rwp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_data    (s_axis_tdata),
    .queue_full (full),
    .push       (push),
    .ev         (wr_data)
  );

  rwp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_data),
    .full    (full),
    .pop     (pop),
    .rd_data (rd_data),
    .empty   (empty)
  );

  rwp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .rd_data   (rd_data),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

`default_nettype wire

FILE: sim/tb_riff_wave_pcm_parser_unit.sv
`timescale 1ns / 100ps

module tb_riff_wave_pcm_parser_unit;

  localparam int N_ITEMS     = 1350;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 250000;

  typedef enum logic [2:0] {
    ST_HEADER,
    ST_FORM,
    ST_FMT,
    ST_DATA,
    ST_SKIP,
    ST_HALT
  } wav_phase_t;

  typedef struct {
    logic [7:0]       data_byte;
    bit               typed;
    rwp_pkg::event_t  want;
  } stim_row_t;

  localparam rwp_pkg::event_t FMT_TOP = '{kind: rwp_pkg::KIND_FORMAT, sample: '0,
                                          rate: 32'hFFFF_FFFF, bits: 16'd16,
                                          err: rwp_pkg::ERR_NOT_WAVE};

  logic                            clk           = 1'b0;
  logic                            rst           = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [rwp_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // data_byte
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // event_kind, sample_value, rate_hz, sample_bits, error_code, zero pad
  logic [rwp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  // parser state as seen by the predictor
  wav_phase_t  ps_phase    = ST_HEADER;
  logic [4:0]  ps_pos      = '0;
  logic [31:0] ps_tag      = '0;
  logic [31:0] ps_left     = '0;
  logic [63:0] ps_fmt      = '0;
  logic [15:0] ps_bps      = '0;
  bit          ps_fmt_seen = 1'b0;
  logic [7:0]  ps_low      = '0;

  rwp_pkg::event_t wav_expect[$];
  logic [7:0]      wav_stream[$];
  int              n_fail     = 0;
  int              n_results  = 0;
  int              n_cycles   = 0;
  int              burst_left = 0;

  // a single fmt chunk: pcm mono, top rate, 16 bits
  stim_row_t dir_rows[24] = '{
    '{8'h66, 1'b0, '0}, '{8'h6D, 1'b0, '0}, '{8'h74, 1'b0, '0}, '{8'h20, 1'b0, '0},
    '{8'h10, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'h01, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h01, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'h02, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h10, 1'b0, '0}, '{8'h00, 1'b1, FMT_TOP}
  };

  riff_wave_pcm_parser_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk = ~clk;

  function automatic rwp_pkg::event_t halt_event(input rwp_pkg::err_t code);
    rwp_pkg::event_t ev;
    ev       = '0;
    ev.kind  = rwp_pkg::KIND_ERROR;
    ev.err   = code;
    ps_phase = ST_HALT;
    return ev;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, output rwp_pkg::event_t ev);
    int          p;
    logic [31:0] prior;
    bit          got;
    p   = ps_pos;
    got = 1'b0;
    ev  = '0;
    case (ps_phase)
      ST_HEADER: begin
        ps_pos = ps_pos + 1'b1;
        if (p < 4) begin
          ps_tag[p*8 +: 8] = b;
          return 1'b0;
        end
        ps_left[(p-4)*8 +: 8] = b;
        if (p != 7) return 1'b0;
        ps_pos = '0;
        if (ps_tag == rwp_pkg::TAG_RIFF) begin
          ps_tag   = '0;
          ps_phase = ST_FORM;
        end else if (ps_tag == rwp_pkg::TAG_FMT) begin
          if (ps_left != 32'd16) begin
            ev = halt_event(rwp_pkg::ERR_FMT_SIZE);
            return 1'b1;
          end
          ps_phase = ST_FMT;
        end else if (ps_tag == rwp_pkg::TAG_DATA) begin
          if (!ps_fmt_seen) begin
            ev = halt_event(rwp_pkg::ERR_NO_FMT);
            return 1'b1;
          end
          if (ps_bps != 16'd8 && ps_bps != 16'd16) begin
            ev = halt_event(rwp_pkg::ERR_BAD_BITS);
            return 1'b1;
          end
          ps_phase = (ps_left == '0) ? ST_HEADER : ST_DATA;
        end else begin
          ps_phase = (ps_left == '0) ? ST_HEADER : ST_SKIP;
        end
        return 1'b0;
      end
      ST_FORM: begin
        ps_tag[(p % 4)*8 +: 8] = b;
        ps_pos = ps_pos + 1'b1;
        if (p >= 3) begin
          ps_pos = '0;
          if (ps_tag != rwp_pkg::TAG_WAVE) begin
            ev = halt_event(rwp_pkg::ERR_NOT_WAVE);
            return 1'b1;
          end
          ps_tag   = '0;
          ps_phase = ST_HEADER;
        end
        return 1'b0;
      end
      ST_FMT: begin
        if (p < 8) ps_fmt[p*8 +: 8] = b;
        else if (p == 14) ps_bps[7:0] = b;
        else if (p == 15) ps_bps[15:8] = b;
        ps_pos = ps_pos + 1'b1;
        if (p < 15) return 1'b0;
        ps_pos = '0;
        if (ps_fmt[15:0] != 16'd1 || ps_fmt[31:16] != 16'd1) begin
          ev = halt_event(rwp_pkg::ERR_NOT_PCM);
          return 1'b1;
        end
        ps_fmt_seen = 1'b1;
        ps_phase    = ST_HEADER;
        ev.kind     = rwp_pkg::KIND_FORMAT;
        ev.rate     = ps_fmt[63:32];
        ev.bits     = ps_bps;
        return 1'b1;
      end
      ST_DATA: begin
        prior   = ps_left;
        ps_left = prior - 32'd1;
        ev.kind = rwp_pkg::KIND_SAMPLE;
        ev.rate = ps_fmt[63:32];
        ev.bits = ps_bps;
        if (ps_bps == 16'd8) begin
          ev.sample = {8'h00, b};
          got       = 1'b1;
        end else if (ps_pos[0] == 1'b0) begin
          // a lone trailing byte is dropped
          if (prior != 32'd1) begin
            ps_low = b;
            ps_pos = 5'd1;
          end
        end else begin
          ps_pos    = '0;
          ev.sample = {b, ps_low};
          got       = 1'b1;
        end
        if (ps_left == '0) begin
          ps_pos   = '0;
          ps_phase = ST_HEADER;
        end
        if (!got) ev = '0;
        return got;
      end
      ST_SKIP: begin
        ps_left = ps_left - 32'd1;
        if (ps_left == '0) begin
          ps_pos   = '0;
          ps_phase = ST_HEADER;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 11))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h7F;
      3:       return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void push_le(input logic [31:0] w, input int nbytes);
    for (int i = 0; i < nbytes; i++) wav_stream.insert(wav_stream.size(), w[i*8 +: 8]);
  endfunction

  function automatic void push_body(input int nbytes);
    for (int i = 0; i < nbytes; i++) wav_stream.insert(wav_stream.size(), pick_byte());
  endfunction

  function automatic void push_fmt(input logic [15:0] code, input logic [15:0] chans,
                                   input logic [15:0] bits);
    push_le(rwp_pkg::TAG_FMT, 4);
    push_le(32'd16, 4);
    push_le(32'(code), 2);
    push_le(32'(chans), 2);
    push_le($urandom, 4);
    push_le($urandom, 4);
    push_le($urandom, 2);
    push_le(32'(bits), 2);
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input rwp_pkg::event_t want = '0);
    rwp_pkg::event_t ev;
    bit              got;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    burst_left--;
    got = parse_byte(b, ev);
    if (got) wav_expect.insert(wav_expect.size(), typed ? want : ev);
  endtask

  initial begin : stimulus
    int          size;
    int          pick;
    int          pause_at;
    logic [31:0] tag;
    logic [15:0] gen_bits;
    logic [15:0] code;
    logic [15:0] chans;

    // well-formed chunks with random content
    gen_bits = 16'd16;
    while (wav_stream.size() < N_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40 && (gen_bits == 16'd8 || gen_bits == 16'd16)) begin
        size = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(0, 24);
        push_le(rwp_pkg::TAG_DATA, 4);
        push_le(size, 4);
        push_body(size);
      end else if (pick < 60) begin
        if ($urandom_range(0, 6) == 0) gen_bits = 16'($urandom);
        else gen_bits = ($urandom_range(0, 1) == 1) ? 16'd16 : 16'd8;
        push_fmt(16'd1, 16'd1, gen_bits);
      end else if (pick < 72) begin
        push_le(rwp_pkg::TAG_RIFF, 4);
        push_le($urandom, 4);
        push_le(rwp_pkg::TAG_WAVE, 4);
      end else begin
        tag = $urandom;
        if (tag == rwp_pkg::TAG_RIFF || tag == rwp_pkg::TAG_FMT ||
            tag == rwp_pkg::TAG_DATA || tag == rwp_pkg::TAG_WAVE)
          tag ^= 32'h8000_0000;
        size = $urandom_range(0, 16);
        push_le(tag, 4);
        push_le(size, 4);
        push_body(size);
      end
    end

    // one broken sequence halts the parser for the rest of the run
    case ($urandom_range(0, 3))
      0: begin
        tag = $urandom;
        if (tag == rwp_pkg::TAG_WAVE) tag ^= 32'h1;
        push_le(rwp_pkg::TAG_RIFF, 4);
        push_le($urandom, 4);
        push_le(tag, 4);
      end
      1: begin
        size = $urandom;
        if (size == 16) size = 17;
        push_le(rwp_pkg::TAG_FMT, 4);
        push_le(size, 4);
      end
      2: begin
        code  = ($urandom_range(0, 1) == 1) ? 16'd1 : 16'($urandom);
        chans = ($urandom_range(0, 1) == 1) ? 16'd1 : 16'($urandom);
        if (code == 16'd1 && chans == 16'd1) chans = 16'd2;
        push_fmt(code, chans, 16'd16);
      end
      default: begin
        gen_bits = 16'($urandom);
        if (gen_bits == 16'd8 || gen_bits == 16'd16) gen_bits = 16'd24;
        push_fmt(16'd1, 16'd1, gen_bits);
        push_le(rwp_pkg::TAG_DATA, 4);
        push_le($urandom_range(0, 40), 4);
      end
    endcase
    push_body(16);

    pause_at = $urandom_range(N_ITEMS / 3, 2 * N_ITEMS / 3);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_byte(dir_rows[i].data_byte, dir_rows[i].typed, dir_rows[i].want);

    for (int i = 0; i < wav_stream.size(); i++) begin
      if (i == pause_at) begin
        s_axis_tvalid <= 1'b0;
        while (wav_expect.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
      end
      send_byte(wav_stream[i]);
    end

    s_axis_tvalid <= 1'b0;
    while (wav_expect.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (n_fail == 0) begin
      $display("** riff_wave_pcm_parser_unit: PASSED **");
    end else begin
      $display("** riff_wave_pcm_parser_unit: FAILED **");
    end
    $finish;
  end

  initial begin : rx_pattern
    int mode;
    int mode_left;
    bit held;
    mode      = 0;
    mode_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && n_results >= 50) begin
        // long hold-off so the result queue fills and the input stalls
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(8, 64);
      end
      mode_left--;
      case (mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    rwp_pkg::event_t seen;
    rwp_pkg::event_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen.kind   = rwp_pkg::kind_t'(m_axis_tdata[1:0]);
      seen.sample = m_axis_tdata[17:2];
      seen.rate   = m_axis_tdata[49:18];
      seen.bits   = m_axis_tdata[65:50];
      seen.err    = rwp_pkg::err_t'(m_axis_tdata[68:66]);
      n_results++;
      if (wav_expect.size() == 0) begin
        $error("result word with nothing expected: %h", m_axis_tdata);
        n_fail++;
      end else begin
        want = wav_expect.pop_front();
        if (seen.kind != want.kind) begin
          $error("event_kind: expected %0d, got %0d", want.kind, seen.kind);
          n_fail++;
        end
        if (seen.sample != want.sample) begin
          $error("sample_value: expected %0d, got %0d", want.sample, seen.sample);
          n_fail++;
        end
        if (seen.rate != want.rate) begin
          $error("rate_hz: expected %0d, got %0d", want.rate, seen.rate);
          n_fail++;
        end
        if (seen.bits != want.bits) begin
          $error("sample_bits: expected %0d, got %0d", want.bits, seen.bits);
          n_fail++;
        end
        if (seen.err != want.err) begin
          $error("error_code: expected %0d, got %0d", want.err, seen.err);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("** riff_wave_pcm_parser_unit: FAILED **");
      $finish;
    end
  end

endmodule
